### src/sdis_pkg.sv
// Shared types and codes for the SD card init sequencer.
// No dependencies; used by the output buffer, the top level and the bench.
package sdis_pkg;

	// Request command codes
	typedef enum logic [1:0] {
		CMD_START   = 2'd0,
		CMD_OUTCOME = 2'd1,
		CMD_READ    = 2'd2,
		CMD_WRITE   = 2'd3
	} sdis_cmd_t;

	// Response kinds handed to the host controller
	localparam logic [1:0] RESP_NONE      = 2'd0;
	localparam logic [1:0] RESP_136       = 2'd1;
	localparam logic [1:0] RESP_48        = 2'd2;
	localparam logic [1:0] RESP_48_BUSY   = 2'd3;

	// Data direction codes
	localparam logic [1:0] DIR_NONE  = 2'd0;
	localparam logic [1:0] DIR_READ  = 2'd1;
	localparam logic [1:0] DIR_WRITE = 2'd2;

	// Result codes
	localparam logic [3:0] RC_OK        = 4'd0;
	localparam logic [3:0] RC_BAD_ECHO  = 4'd1;
	localparam logic [3:0] RC_NO_CARD   = 4'd2;
	localparam logic [3:0] RC_CMD2_FAIL = 4'd3;
	localparam logic [3:0] RC_CMD3_FAIL = 4'd4;
	localparam logic [3:0] RC_CMD9_FAIL = 4'd5;
	localparam logic [3:0] RC_CMD7_FAIL = 4'd6;
	localparam logic [3:0] RC_ACMD6_FAIL = 4'd7;
	localparam logic [3:0] RC_CMD16_FAIL = 4'd8;
	localparam logic [3:0] RC_BLOCK_FAIL = 4'd9;

	// Configuration register indexes
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DATA_W = 24;
	localparam logic [CFG_IDX_W-1:0] REG_ECHO_LIMIT  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_READY_LIMIT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BLOCK_LEN   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CHECK_PAT   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_OCR_WINDOW  = 3'd4;

	// Register reset values
	localparam logic [7:0]  ECHO_LIMIT_RST  = 8'd30;
	localparam logic [9:0]  READY_LIMIT_RST = 10'd150;
	localparam logic [11:0] BLOCK_LEN_RST   = 12'd512;
	localparam logic [11:0] CHECK_PAT_RST   = 12'h1aa;
	localparam logic [23:0] OCR_WINDOW_RST  = 24'hff8000;

	// One result word
	typedef struct packed {
		logic        issue;
		logic [5:0]  cmd_index;
		logic [31:0] cmd_arg;
		logic [1:0]  resp_kind;
		logic        index_check;
		logic        crc_check;
		logic [1:0]  data_dir;
		logic        delay_first;
		logic        fast_clock;
		logic        wide_bus;
		logic        done_res;
		logic [3:0]  result_code;
	} sdis_res_t;

endpackage

### src/sdis_req_if.sv
// Request channel: valid/ready handshake with the input word fields.
// Depends on nothing.
interface sdis_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  command;
	logic        cmd_complete;
	logic        cmd_timeout;
	logic        error_summary;
	logic [31:0] response;
	logic [31:0] block_index;

	modport source (output valid, command, cmd_complete, cmd_timeout, error_summary,
		response, block_index, input ready);
	modport sink (input valid, command, cmd_complete, cmd_timeout, error_summary,
		response, block_index, output ready);
endinterface

### src/sdis_rsp_if.sv
// Result channel: valid/ready handshake with the result word fields.
// Depends on nothing.
interface sdis_rsp_if;
	logic        valid;
	logic        ready;
	logic        issue;
	logic [5:0]  cmd_index;
	logic [31:0] cmd_arg;
	logic [1:0]  resp_kind;
	logic        index_check;
	logic        crc_check;
	logic [1:0]  data_dir;
	logic        delay_first;
	logic        fast_clock;
	logic        wide_bus;
	logic        done_res;
	logic [3:0]  result_code;

	modport source (output valid, issue, cmd_index, cmd_arg, resp_kind, index_check,
		crc_check, data_dir, delay_first, fast_clock, wide_bus, done_res, result_code,
		input ready);
	modport sink (input valid, issue, cmd_index, cmd_arg, resp_kind, index_check,
		crc_check, data_dir, delay_first, fast_clock, wide_bus, done_res, result_code,
		output ready);
endinterface

### src/sdis_out_buf.sv
// Output register with one skid entry for the result channel.
// Depends on sdis_pkg and sdis_rsp_if.
module sdis_out_buf (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push_valid,
	input  sdis_pkg::sdis_res_t push_data,
	output logic              push_ready,
	sdis_rsp_if.source        rsp
);
	import sdis_pkg::*;

	logic      out_v_q;
	sdis_res_t out_d_q;
	logic      sk_v_q;
	sdis_res_t sk_d_q;
	logic      pop;

	assign pop        = out_v_q && rsp.ready;
	assign push_ready = !sk_v_q;

	// Hold control: drain the skid entry first, else load the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			sk_v_q  <= 1'b0;
		end else if (sk_v_q) begin
			if (pop) begin
				sk_v_q <= 1'b0;
			end
		end else if (push_valid) begin
			if (!out_v_q || pop) begin
				out_v_q <= 1'b1;
			end else begin
				sk_v_q <= 1'b1;
			end
		end else if (pop) begin
			out_v_q <= 1'b0;
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (sk_v_q) begin
			if (pop) begin
				out_d_q <= sk_d_q;
			end
		end else if (push_valid) begin
			if (!out_v_q || pop) begin
				out_d_q <= push_data;
			end else begin
				sk_d_q <= push_data;
			end
		end
	end

	assign rsp.valid       = out_v_q;
	assign rsp.issue       = out_d_q.issue;
	assign rsp.cmd_index   = out_d_q.cmd_index;
	assign rsp.cmd_arg     = out_d_q.cmd_arg;
	assign rsp.resp_kind   = out_d_q.resp_kind;
	assign rsp.index_check = out_d_q.index_check;
	assign rsp.crc_check   = out_d_q.crc_check;
	assign rsp.data_dir    = out_d_q.data_dir;
	assign rsp.delay_first = out_d_q.delay_first;
	assign rsp.fast_clock  = out_d_q.fast_clock;
	assign rsp.wide_bus    = out_d_q.wide_bus;
	assign rsp.done_res    = out_d_q.done_res;
	assign rsp.result_code = out_d_q.result_code;

	// The skid entry only fills behind a held output word
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		sk_v_q |-> out_v_q) else $error("skid entry valid with empty output register");
	// A stalled output word with a full skid drains into the output register
	a_skid_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(sk_v_q && pop) |=> (out_v_q && !sk_v_q))
		else $error("skid entry not moved on pop");
	// A push is never taken while the skid is full
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(push_valid && sk_v_q)) else $error("push while buffer full");
endmodule

### src/sd_card_init_sequencer_top.sv
// SD card init sequencer: maps each request word to the next command or a result code.
// Depends on sdis_pkg, sdis_req_if, sdis_rsp_if and sdis_out_buf.
// An accepted request's result word is registered into the output register, or into the skid entry behind a held word.
// Throughput: one request per cycle while req.ready is high; the next state is combinational logic.
// req.ready drops only while the output register and its skid entry are both full.
// Reset (arst_n low) returns to idle, clears all state and loads register defaults.
module sd_card_init_sequencer_top (
	input  logic                                clk,
	input  logic                                arst_n,
	sdis_req_if.sink                            req,
	sdis_rsp_if.source                          rsp,
	input  logic                                cfg_we,
	input  logic [sdis_pkg::CFG_IDX_W-1:0]      cfg_idx,
	input  logic [sdis_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
	import sdis_pkg::*;

	typedef enum logic [3:0] {
		PH_IDLE   = 4'd0,
		PH_CMD0   = 4'd1,
		PH_CMD8   = 4'd2,
		PH_RDY55  = 4'd3,
		PH_ACMD41 = 4'd4,
		PH_CMD2   = 4'd5,
		PH_CMD3   = 4'd6,
		PH_CMD9   = 4'd7,
		PH_CMD7   = 4'd8,
		PH_BUS55  = 4'd9,
		PH_ACMD6  = 4'd10,
		PH_CMD16  = 4'd11,
		PH_BLOCK  = 4'd12
	} phase_t;

	// Card command numbers
	localparam logic [5:0] IDX_CMD0   = 6'd0;
	localparam logic [5:0] IDX_CMD2   = 6'd2;
	localparam logic [5:0] IDX_CMD3   = 6'd3;
	localparam logic [5:0] IDX_ACMD6  = 6'd6;
	localparam logic [5:0] IDX_CMD7   = 6'd7;
	localparam logic [5:0] IDX_CMD8   = 6'd8;
	localparam logic [5:0] IDX_CMD9   = 6'd9;
	localparam logic [5:0] IDX_CMD16  = 6'd16;
	localparam logic [5:0] IDX_CMD17  = 6'd17;
	localparam logic [5:0] IDX_CMD24  = 6'd24;
	localparam logic [5:0] IDX_ACMD41 = 6'd41;
	localparam logic [5:0] IDX_CMD55  = 6'd55;
	localparam logic [31:0] ARG_BUS4  = 32'd2;

	// Configuration registers
	logic [7:0]  echo_lim_q;
	logic [9:0]  ready_lim_q;
	logic [11:0] blk_len_q;
	logic [11:0] check_pat_q;
	logic [23:0] ocr_q;

	// Sequencer state
	phase_t      phase_q, phase_d;
	logic [9:0]  try_q, try_d;
	logic        v2_q, v2_d;
	logic [15:0] rca_q, rca_d;
	logic        byte_q, byte_d;
	logic [31:0] last_q, last_d;
	logic        fast_q, fast_d;
	logic        wide_q, wide_d;

	logic        accept;
	logic        push_valid;
	logic        push_ready;
	sdis_res_t   res;
	sdis_cmd_t   cmd;
	logic        cap;
	logic [9:0]  try_inc;

	assign accept  = req.valid && req.ready;
	assign req.ready = push_ready;
	assign cmd     = sdis_cmd_t'(req.command);
	assign try_inc = try_q + 10'd1;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			echo_lim_q  <= ECHO_LIMIT_RST;
			ready_lim_q <= READY_LIMIT_RST;
			blk_len_q   <= BLOCK_LEN_RST;
			check_pat_q <= CHECK_PAT_RST;
			ocr_q       <= OCR_WINDOW_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_ECHO_LIMIT:  echo_lim_q  <= cfg_wdata[7:0];
				REG_READY_LIMIT: ready_lim_q <= cfg_wdata[9:0];
				REG_BLOCK_LEN:   blk_len_q   <= cfg_wdata[11:0];
				REG_CHECK_PAT:   check_pat_q <= cfg_wdata[11:0];
				REG_OCR_WINDOW:  ocr_q       <= cfg_wdata[23:0];
				default: ;
			endcase
		end
	end

	// Next command or result for the request word
	always_comb begin
		phase_d = phase_q;
		try_d   = try_q;
		v2_d    = v2_q;
		rca_d   = rca_q;
		byte_d  = byte_q;
		last_d  = last_q;
		fast_d  = fast_q;
		wide_d  = wide_q;
		res     = '0;
		push_valid = 1'b0;
		cap = (phase_q == PH_CMD8) || (phase_q == PH_ACMD41) || (phase_q == PH_CMD2) ||
			(phase_q == PH_CMD3) || (phase_q == PH_CMD9) || (phase_q == PH_CMD7) ||
			(phase_q == PH_ACMD6) || (phase_q == PH_CMD16);

		unique case (cmd)
			CMD_START: begin
				push_valid = 1'b1;
				v2_d  = 1'b0;
				try_d = '0;
				res.issue = 1'b1;
				res.cmd_index = IDX_CMD0;
				phase_d = PH_CMD0;
			end
			CMD_READ, CMD_WRITE: begin
				if (phase_q == PH_IDLE) begin
					push_valid = 1'b1;
					res.issue = 1'b1;
					res.cmd_index = (cmd == CMD_READ) ? IDX_CMD17 : IDX_CMD24;
					res.cmd_arg = byte_q ? {req.block_index[22:0], 9'd0} : req.block_index;
					res.resp_kind = RESP_48;
					res.index_check = 1'b1;
					res.crc_check = 1'b1;
					res.data_dir = (cmd == CMD_READ) ? DIR_READ : DIR_WRITE;
					phase_d = PH_BLOCK;
				end
			end
			CMD_OUTCOME: begin
				if (phase_q != PH_IDLE && phase_q <= PH_BLOCK) begin
					push_valid = 1'b1;
					if (cap && !req.error_summary) begin
						last_d = req.response;
					end
					// Default to a plain 48-bit response command with both checks
					res.resp_kind = RESP_48;
					res.index_check = 1'b1;
					res.crc_check = 1'b1;
					res.issue = 1'b1;
					unique case (phase_q)
						PH_CMD0: begin
							try_d = '0;
							if (echo_lim_q == 8'd0) begin
								res.cmd_index = IDX_CMD55;
								phase_d = PH_RDY55;
								// A zero ready limit ends with no card at once
								if (ready_lim_q == 10'd0) begin
									res.issue = 1'b0;
									res.result_code = RC_NO_CARD;
								end
							end else begin
								res.cmd_index = IDX_CMD8;
								res.cmd_arg = {20'd0, check_pat_q};
								phase_d = PH_CMD8;
							end
						end
						PH_CMD8: begin
							if (req.cmd_timeout) begin
								if (try_inc < {2'd0, echo_lim_q}) begin
									try_d = try_inc;
									res.cmd_index = IDX_CMD8;
									res.cmd_arg = {20'd0, check_pat_q};
									res.delay_first = 1'b1;
									phase_d = PH_CMD8;
								end else begin
									try_d = '0;
									res.cmd_index = IDX_CMD55;
									res.delay_first = 1'b1;
									phase_d = PH_RDY55;
									if (ready_lim_q == 10'd0) begin
										res.issue = 1'b0;
										res.result_code = RC_NO_CARD;
									end
								end
							end else if (req.cmd_complete &&
								last_d == {20'd0, check_pat_q}) begin
								v2_d = 1'b1;
								try_d = '0;
								res.cmd_index = IDX_CMD55;
								phase_d = PH_RDY55;
								if (ready_lim_q == 10'd0) begin
									res.issue = 1'b0;
									res.result_code = RC_NO_CARD;
								end
							end else begin
								res.issue = 1'b0;
								res.result_code = RC_BAD_ECHO;
							end
						end
						PH_RDY55: begin
							if (req.cmd_complete) begin
								res.cmd_index = IDX_ACMD41;
								res.cmd_arg = {1'b0, v2_q, 6'd0, ocr_q};
								res.index_check = 1'b0;
								res.crc_check = 1'b0;
								phase_d = PH_ACMD41;
							end else if (req.cmd_timeout) begin
								try_d = try_inc;
								res.cmd_index = IDX_CMD55;
								res.delay_first = 1'b1;
								phase_d = PH_RDY55;
								res.issue = (try_inc < ready_lim_q);
							end else begin
								res.issue = 1'b0;
							end
							if (!res.issue) res.result_code = RC_NO_CARD;
						end
						PH_ACMD41: begin
							if (!req.cmd_timeout && req.cmd_complete && last_d[31]) begin
								byte_d = !v2_q;
								res.cmd_index = IDX_CMD2;
								res.resp_kind = RESP_136;
								res.index_check = 1'b0;
								phase_d = PH_CMD2;
							end else if (req.cmd_timeout || req.cmd_complete) begin
								try_d = try_inc;
								res.cmd_index = IDX_CMD55;
								res.delay_first = 1'b1;
								phase_d = PH_RDY55;
								res.issue = (try_inc < ready_lim_q);
							end else begin
								res.issue = 1'b0;
							end
							if (!res.issue) res.result_code = RC_NO_CARD;
						end
						PH_CMD2: begin
							res.issue = req.cmd_complete;
							res.cmd_index = IDX_CMD3;
							phase_d = PH_CMD3;
							if (!req.cmd_complete) res.result_code = RC_CMD2_FAIL;
						end
						PH_CMD3: begin
							res.issue = req.cmd_complete;
							if (req.cmd_complete) begin
								rca_d = last_d[31:16];
								res.cmd_index = IDX_CMD9;
								res.cmd_arg = {last_d[31:16], 16'd0};
								res.resp_kind = RESP_136;
								res.index_check = 1'b0;
								phase_d = PH_CMD9;
							end else begin
								res.result_code = RC_CMD3_FAIL;
							end
						end
						PH_CMD9: begin
							res.issue = req.cmd_complete;
							if (req.cmd_complete) begin
								fast_d = 1'b1;
								res.cmd_index = IDX_CMD7;
								res.cmd_arg = {rca_q, 16'd0};
								res.resp_kind = RESP_48_BUSY;
								phase_d = PH_CMD7;
							end else begin
								res.result_code = RC_CMD9_FAIL;
							end
						end
						PH_CMD7: begin
							res.issue = req.cmd_complete;
							res.cmd_index = IDX_CMD55;
							res.cmd_arg = {rca_q, 16'd0};
							phase_d = PH_BUS55;
							if (!req.cmd_complete) res.result_code = RC_CMD7_FAIL;
						end
						PH_BUS55: begin
							res.issue = req.cmd_complete;
							res.cmd_index = IDX_ACMD6;
							res.cmd_arg = ARG_BUS4;
							phase_d = PH_ACMD6;
							if (!req.cmd_complete) res.result_code = RC_ACMD6_FAIL;
						end
						PH_ACMD6: begin
							res.issue = req.cmd_complete;
							if (req.cmd_complete) begin
								wide_d = 1'b1;
								res.cmd_index = IDX_CMD16;
								res.cmd_arg = {20'd0, blk_len_q};
								phase_d = PH_CMD16;
							end else begin
								res.result_code = RC_ACMD6_FAIL;
							end
						end
						PH_CMD16: begin
							res.issue = 1'b0;
							res.result_code = req.cmd_complete ? RC_OK : RC_CMD16_FAIL;
						end
						default: begin
							res.issue = 1'b0;
							res.result_code = req.cmd_complete ? RC_OK : RC_BLOCK_FAIL;
						end
					endcase
					// A finished job drops all command fields and returns to idle
					if (!res.issue) begin
						res.cmd_index = '0;
						res.cmd_arg = '0;
						res.resp_kind = RESP_NONE;
						res.index_check = 1'b0;
						res.crc_check = 1'b0;
						res.data_dir = DIR_NONE;
						res.delay_first = 1'b0;
						res.done_res = 1'b1;
						phase_d = PH_IDLE;
					end
				end
			end
			default: ;
		endcase
		res.fast_clock = fast_d;
		res.wide_bus = wide_d;
	end

	// Hold sequencer state; advance only on an accepted word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			try_q   <= '0;
			v2_q    <= 1'b0;
			rca_q   <= '0;
			byte_q  <= 1'b0;
			last_q  <= '0;
			fast_q  <= 1'b0;
			wide_q  <= 1'b0;
		end else if (accept) begin
			phase_q <= phase_d;
			try_q   <= try_d;
			v2_q    <= v2_d;
			rca_q   <= rca_d;
			byte_q  <= byte_d;
			last_q  <= last_d;
			fast_q  <= fast_d;
			wide_q  <= wide_d;
		end
	end

	sdis_out_buf u_out_buf (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (accept && push_valid),
		.push_data  (res),
		.push_ready (push_ready),
		.rsp        (rsp)
	);

	// Every result word is either a command or a finish, never both
	a_issue_xor_done: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && push_valid) |-> (res.issue != res.done_res))
		else $error("result word is neither or both command and finish");
	// A start always restarts at CMD0
	a_start_cmd0: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && cmd == CMD_START) |=> (phase_q == PH_CMD0 && !v2_q && try_q == '0))
		else $error("start did not restart the sequence");
	// The wide bus is only selected after the clock speed-up
	a_wide_after_fast: assert property (@(posedge clk) disable iff (!arst_n)
		wide_q |-> fast_q) else $error("wide bus without fast clock");
	// A finish word always sends the sequencer back to idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && push_valid && res.done_res) |=> phase_q == PH_IDLE)
		else $error("finished job left sequencer busy");
endmodule

### test/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for sd_card_init_sequencer_top: walks a short table of request words,
// then random init, read and write traffic across several register settings.
// Depends on sdis_pkg, sdis_req_if, sdis_rsp_if and the sequencer RTL.
module tb_top;
	import sdis_pkg::*;

	localparam int HOLD_CYCLES = 150;
	localparam int STALL_LIMIT = 1000;
	localparam int WORDS_PER_SETTING = 70;

	// SD command indexes the sequencer asks for
	localparam logic [5:0] SD_GO_IDLE       = 6'd0;
	localparam logic [5:0] SD_ALL_SEND_CID  = 6'd2;
	localparam logic [5:0] SD_SEND_RCA      = 6'd3;
	localparam logic [5:0] SD_SET_BUS_WIDTH = 6'd6;
	localparam logic [5:0] SD_SELECT        = 6'd7;
	localparam logic [5:0] SD_SEND_IF_COND  = 6'd8;
	localparam logic [5:0] SD_SEND_CSD      = 6'd9;
	localparam logic [5:0] SD_SET_BLOCKLEN  = 6'd16;
	localparam logic [5:0] SD_READ_BLOCK    = 6'd17;
	localparam logic [5:0] SD_WRITE_BLOCK   = 6'd24;
	localparam logic [5:0] SD_SEND_OP_COND  = 6'd41;
	localparam logic [5:0] SD_APP_CMD       = 6'd55;
	localparam logic [31:0] BUS_4BIT_ARG    = 32'd2;

	typedef enum logic [3:0] {
		ST_IDLE, ST_CMD0, ST_CMD8, ST_RDY55, ST_ACMD41, ST_CMD2, ST_CMD3,
		ST_CMD9, ST_CMD7, ST_BUS55, ST_ACMD6, ST_CMD16, ST_BLOCK
	} seq_state_t;

	typedef struct packed {
		sdis_cmd_t   command;
		logic        comp;
		logic        tmo;
		logic        err;
		logic [31:0] response;
		logic [31:0] block_index;
	} req_word_t;

	typedef struct {
		req_word_t w;
		bit        typed;
		sdis_res_t want;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	sdis_req_if req_bus();
	sdis_rsp_if rsp_bus();

	sd_card_init_sequencer_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req_bus),
		.rsp      (rsp_bus),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_wdata(cfg_wdata)
	);

	always #5 clk = ~clk;

	// Sequencer shadow: registers and state as the block should hold them
	logic [7:0]  lim_echo  = ECHO_LIMIT_RST;
	logic [9:0]  lim_ready = READY_LIMIT_RST;
	logic [11:0] blk_len   = BLOCK_LEN_RST;
	logic [11:0] pattern   = CHECK_PAT_RST;
	logic [23:0] ocr       = OCR_WINDOW_RST;
	seq_state_t  st        = ST_IDLE;
	logic [9:0]  tries     = '0;
	logic        v2        = 1'b0;
	logic [15:0] card_addr = '0;
	logic        byte_addr = 1'b0;
	logic [31:0] last_rsp  = '0;
	logic        fast      = 1'b0;
	logic        wide      = 1'b0;

	sdis_res_t planned_words[$];

	bit calm = 1'b0;
	bit hold_req = 1'b0;
	int mismatches = 0;
	int words_sent = 0;
	int words_ignored = 0;
	int words_checked = 0;
	int inits_ok = 0;
	int block_cmds = 0;
	int settings_used = 1;
	int quiet_cycles = 0;

	function automatic sdis_res_t cmd_word(logic [5:0] idx, logic [31:0] arg, logic [1:0] kind,
			logic ichk, logic cchk, logic [1:0] dir, logic delay);
		sdis_res_t r;
		r = '0;
		r.issue = 1'b1;
		r.cmd_index = idx;
		r.cmd_arg = arg;
		r.resp_kind = kind;
		r.index_check = ichk;
		r.crc_check = cchk;
		r.data_dir = dir;
		r.delay_first = delay;
		return r;
	endfunction

	function automatic sdis_res_t done_word(logic [3:0] code);
		sdis_res_t r;
		r = '0;
		r.done_res = 1'b1;
		r.result_code = code;
		return r;
	endfunction

	// Open the CMD55/ACMD41 loop, or give up at once on a zero limit
	function automatic sdis_res_t ready_first(logic delay);
		tries = '0;
		if (lim_ready == '0) begin
			st = ST_IDLE;
			return done_word(RC_NO_CARD);
		end
		st = ST_RDY55;
		return cmd_word(SD_APP_CMD, '0, RESP_48, 1'b1, 1'b1, DIR_NONE, delay);
	endfunction

	// Count one failed ready attempt and go round again if allowed
	function automatic sdis_res_t ready_again();
		tries = tries + 10'd1;
		if (tries < lim_ready) begin
			st = ST_RDY55;
			return cmd_word(SD_APP_CMD, '0, RESP_48, 1'b1, 1'b1, DIR_NONE, 1'b1);
		end
		st = ST_IDLE;
		return done_word(RC_NO_CARD);
	endfunction

	// Advance the shadow by one request word; returns 1 when a result word is due
	function automatic bit sequence_step(input req_word_t w, output sdis_res_t r);
		logic [31:0] rca;
		bit cap;
		rca = {card_addr, 16'h0};
		r = '0;
		case (w.command)
			CMD_START: begin
				v2 = 1'b0;
				tries = '0;
				st = ST_CMD0;
				r = cmd_word(SD_GO_IDLE, '0, RESP_NONE, 1'b0, 1'b0, DIR_NONE, 1'b0);
			end
			CMD_READ, CMD_WRITE: begin
				if (st != ST_IDLE)
					return 1'b0;
				r = cmd_word(w.command == CMD_READ ? SD_READ_BLOCK : SD_WRITE_BLOCK,
					byte_addr ? (w.block_index << 9) : w.block_index, RESP_48, 1'b1, 1'b1,
					w.command == CMD_READ ? DIR_READ : DIR_WRITE, 1'b0);
				st = ST_BLOCK;
				block_cmds++;
			end
			default: begin
				if (st == ST_IDLE)
					return 1'b0;
				cap = !(st == ST_CMD0 || st == ST_RDY55 || st == ST_BUS55 || st == ST_BLOCK);
				if (cap && !w.err)
					last_rsp = w.response;
				case (st)
					ST_CMD0: begin
						tries = '0;
						if (lim_echo == '0) begin
							r = ready_first(1'b0);
						end else begin
							st = ST_CMD8;
							r = cmd_word(SD_SEND_IF_COND, {20'h0, pattern}, RESP_48, 1'b1, 1'b1,
								DIR_NONE, 1'b0);
						end
					end
					ST_CMD8: begin
						if (w.tmo) begin
							tries = tries + 10'd1;
							if (tries < {2'b0, lim_echo})
								r = cmd_word(SD_SEND_IF_COND, {20'h0, pattern}, RESP_48, 1'b1,
									1'b1, DIR_NONE, 1'b1);
							else
								r = ready_first(1'b1);
						end else if (w.comp && last_rsp == {20'h0, pattern}) begin
							v2 = 1'b1;
							r = ready_first(1'b0);
						end else begin
							st = ST_IDLE;
							r = done_word(RC_BAD_ECHO);
						end
					end
					ST_RDY55: begin
						if (w.comp) begin
							st = ST_ACMD41;
							r = cmd_word(SD_SEND_OP_COND, {1'b0, v2, 6'h0, ocr}, RESP_48, 1'b0,
								1'b0, DIR_NONE, 1'b0);
						end else if (w.tmo) begin
							r = ready_again();
						end else begin
							st = ST_IDLE;
							r = done_word(RC_NO_CARD);
						end
					end
					ST_ACMD41: begin
						if (w.tmo) begin
							r = ready_again();
						end else if (!w.comp) begin
							st = ST_IDLE;
							r = done_word(RC_NO_CARD);
						end else if (last_rsp[31]) begin
							byte_addr = !v2;
							st = ST_CMD2;
							r = cmd_word(SD_ALL_SEND_CID, '0, RESP_136, 1'b0, 1'b1, DIR_NONE, 1'b0);
						end else begin
							r = ready_again();
						end
					end
					ST_CMD2: begin
						st = w.comp ? ST_CMD3 : ST_IDLE;
						r = w.comp ? cmd_word(SD_SEND_RCA, '0, RESP_48, 1'b1, 1'b1, DIR_NONE, 1'b0)
							: done_word(RC_CMD2_FAIL);
					end
					ST_CMD3: begin
						if (w.comp) begin
							card_addr = last_rsp[31:16];
							st = ST_CMD9;
							r = cmd_word(SD_SEND_CSD, {card_addr, 16'h0}, RESP_136, 1'b0, 1'b1,
								DIR_NONE, 1'b0);
						end else begin
							st = ST_IDLE;
							r = done_word(RC_CMD3_FAIL);
						end
					end
					ST_CMD9: begin
						if (w.comp) begin
							fast = 1'b1;
							st = ST_CMD7;
							r = cmd_word(SD_SELECT, rca, RESP_48_BUSY, 1'b1, 1'b1, DIR_NONE, 1'b0);
						end else begin
							st = ST_IDLE;
							r = done_word(RC_CMD9_FAIL);
						end
					end
					ST_CMD7: begin
						st = w.comp ? ST_BUS55 : ST_IDLE;
						r = w.comp ? cmd_word(SD_APP_CMD, rca, RESP_48, 1'b1, 1'b1, DIR_NONE, 1'b0)
							: done_word(RC_CMD7_FAIL);
					end
					ST_BUS55: begin
						st = w.comp ? ST_ACMD6 : ST_IDLE;
						r = w.comp ? cmd_word(SD_SET_BUS_WIDTH, BUS_4BIT_ARG, RESP_48, 1'b1, 1'b1,
							DIR_NONE, 1'b0) : done_word(RC_ACMD6_FAIL);
					end
					ST_ACMD6: begin
						if (w.comp) begin
							wide = 1'b1;
							st = ST_CMD16;
							r = cmd_word(SD_SET_BLOCKLEN, {20'h0, blk_len}, RESP_48, 1'b1, 1'b1,
								DIR_NONE, 1'b0);
						end else begin
							st = ST_IDLE;
							r = done_word(RC_ACMD6_FAIL);
						end
					end
					ST_CMD16: begin
						st = ST_IDLE;
						if (w.comp)
							inits_ok++;
						r = done_word(w.comp ? RC_OK : RC_CMD16_FAIL);
					end
					default: begin
						st = ST_IDLE;
						r = done_word(w.comp ? RC_OK : RC_BLOCK_FAIL);
					end
				endcase
			end
		endcase
		r.fast_clock = fast;
		r.wide_bus = wide;
		return 1'b1;
	endfunction

	function automatic req_word_t mk_word(sdis_cmd_t c, logic comp, logic tmo, logic err,
			logic [31:0] rsp, logic [31:0] blk);
		req_word_t w;
		w.command = c;
		w.comp = comp;
		w.tmo = tmo;
		w.err = err;
		w.response = rsp;
		w.block_index = blk;
		return w;
	endfunction

	// Pick the next word: mostly the outcome a working card gives, some failures and noise
	function automatic req_word_t pick_word();
		req_word_t w;
		int roll;
		w.command = CMD_OUTCOME;
		w.comp = 1'($urandom_range(0, 1));
		w.tmo = 1'($urandom_range(0, 1));
		w.err = 1'($urandom_range(0, 1));
		w.response = $urandom();
		case ($urandom_range(0, 7))
			0: w.block_index = '0;
			1: w.block_index = '1;
			2: w.block_index = 32'h007f_ffff;
			default: w.block_index = $urandom();
		endcase
		roll = $urandom_range(0, 99);
		if (roll < 4) begin
			w.command = sdis_cmd_t'($urandom_range(0, 3));
			return w;
		end
		if (roll < 7 || (st == ST_IDLE && roll < 40)) begin
			w.command = CMD_START;
			return w;
		end
		if (st == ST_IDLE) begin
			w.command = roll < 70 ? CMD_READ : CMD_WRITE;
			return w;
		end
		w.err = ($urandom_range(0, 9) == 0);
		roll = $urandom_range(0, 99);
		case (st)
			ST_CMD8: begin
				if (roll < 25) begin
					w.tmo = 1'b1;
				end else if (roll < 85) begin
					w.comp = 1'b1;
					w.tmo = 1'b0;
					w.response = {20'h0, pattern};
				end else begin
					w.tmo = 1'b0;
				end
			end
			ST_RDY55: begin
				w.comp = roll < 82;
				w.tmo = roll >= 82 && roll < 94;
			end
			ST_ACMD41: begin
				w.tmo = roll < 8;
				w.comp = roll >= 14;
				w.response[31] = roll >= 35;
			end
			default: begin
				w.comp = roll < 90;
			end
		endcase
		return w;
	endfunction

	task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			mismatches++;
		end
	endtask

	// Offer one word, fold it into the shadow once taken, then maybe idle
	task automatic offer(input req_word_t w, input bit typed, input sdis_res_t want,
			output bit hit);
		sdis_res_t got;
		req_bus.valid <= 1'b1;
		req_bus.command <= w.command;
		req_bus.cmd_complete <= w.comp;
		req_bus.cmd_timeout <= w.tmo;
		req_bus.error_summary <= w.err;
		req_bus.response <= w.response;
		req_bus.block_index <= w.block_index;
		do @(posedge clk); while (req_bus.ready !== 1'b1);
		hit = sequence_step(w, got);
		if (hit)
			planned_words.push_back(typed ? want : got);
		else
			words_ignored++;
		words_sent++;
		// Keep valid low and idle while each 36 percent roll succeeds
		if (!calm) begin
			while ($urandom_range(0, 99) < 36) begin
				req_bus.valid <= 1'b0;
				@(posedge clk);
			end
		end
	endtask

	// Drop valid, wait for every due word, then let the output buffer go quiet
	task automatic settle();
		req_bus.valid <= 1'b0;
		while (planned_words.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic program_regs(input logic [7:0] echo, input logic [9:0] rdy,
			input logic [11:0] blen, input logic [11:0] pat, input logic [23:0] win);
		logic [CFG_IDX_W-1:0] idx [5];
		logic [CFG_DATA_W-1:0] vals [5];
		idx = '{REG_ECHO_LIMIT, REG_READY_LIMIT, REG_BLOCK_LEN, REG_CHECK_PAT, REG_OCR_WINDOW};
		vals = '{24'(echo), 24'(rdy), 24'(blen), 24'(pat), win};
		for (int i = 0; i < 5; i++) begin
			cfg_we <= 1'b1;
			cfg_idx <= idx[i];
			cfg_wdata <= vals[i];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		lim_echo = echo;
		lim_ready = rdy;
		blk_len = blen;
		pattern = pat;
		ocr = win;
		settings_used++;
	endtask

	// Pace the result side; a hold request stalls it for a long stretch
	initial begin : result_pacing
		int hold_left;
		hold_left = 0;
		rsp_bus.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				hold_left--;
				rsp_bus.ready <= 1'b0;
			end else if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_CYCLES;
				rsp_bus.ready <= 1'b0;
			end else begin
				rsp_bus.ready <= calm || $urandom_range(0, 99) >= 36;
			end
		end
	end

	// Compare each taken result word with the oldest due one
	always @(posedge clk) begin : result_check
		sdis_res_t want;
		if (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
			if (planned_words.size() == 0) begin
				$error("result word with none due: cmd_index %0d, done_res %0b",
					rsp_bus.cmd_index, rsp_bus.done_res);
				mismatches++;
			end else begin
				want = planned_words.pop_front();
				words_checked++;
				check_field("issue", 32'(want.issue), 32'(rsp_bus.issue));
				check_field("cmd_index", 32'(want.cmd_index), 32'(rsp_bus.cmd_index));
				check_field("cmd_arg", want.cmd_arg, rsp_bus.cmd_arg);
				check_field("resp_kind", 32'(want.resp_kind), 32'(rsp_bus.resp_kind));
				check_field("index_check", 32'(want.index_check), 32'(rsp_bus.index_check));
				check_field("crc_check", 32'(want.crc_check), 32'(rsp_bus.crc_check));
				check_field("data_dir", 32'(want.data_dir), 32'(rsp_bus.data_dir));
				check_field("delay_first", 32'(want.delay_first), 32'(rsp_bus.delay_first));
				check_field("fast_clock", 32'(want.fast_clock), 32'(rsp_bus.fast_clock));
				check_field("wide_bus", 32'(want.wide_bus), 32'(rsp_bus.wide_bus));
				check_field("done_res", 32'(want.done_res), 32'(rsp_bus.done_res));
				check_field("result_code", 32'(want.result_code), 32'(rsp_bus.result_code));
			end
		end
	end

	// End the run if neither side moves a word for too long
	always @(posedge clk) begin : stall_watch
		if ((req_bus.valid === 1'b1 && req_bus.ready === 1'b1) ||
				(rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("stalled for %0d cycles with %0d words due", quiet_cycles,
				planned_words.size());
			$display("tb_top failed");
			$finish;
		end
	end

	initial begin : stimulus
		stim_row_t directed[$];
		req_word_t w;
		bit hit;
		int made;
		arst_n = 1'b0;
		cfg_we <= 1'b0;
		cfg_idx <= REG_ECHO_LIMIT;
		cfg_wdata <= '0;
		req_bus.valid <= 1'b0;
		req_bus.command <= CMD_START;
		req_bus.cmd_complete <= 1'b0;
		req_bus.cmd_timeout <= 1'b0;
		req_bus.error_summary <= 1'b0;
		req_bus.response <= '0;
		req_bus.block_index <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: idle corner cases, block access, one full init, restart and bad echo
		directed.push_back('{mk_word(CMD_OUTCOME, 1'b1, 1'b0, 1'b0, '0, '0), 1'b0, '0});
		directed.push_back('{mk_word(CMD_READ, 1'b0, 1'b0, 1'b0, '0, '1), 1'b1,
			cmd_word(SD_READ_BLOCK, '1, RESP_48, 1'b1, 1'b1, DIR_READ, 1'b0)});
		directed.push_back('{mk_word(CMD_OUTCOME, 1'b0, 1'b1, 1'b1, '1, '0), 1'b1,
			done_word(RC_BLOCK_FAIL)});
		directed.push_back('{mk_word(CMD_WRITE, 1'b1, 1'b1, 1'b1, '1, '0), 1'b1,
			cmd_word(SD_WRITE_BLOCK, '0, RESP_48, 1'b1, 1'b1, DIR_WRITE, 1'b0)});
		directed.push_back('{mk_word(CMD_READ, 1'b0, 1'b0, 1'b0, '0, 32'h1234), 1'b0, '0});
		directed.push_back('{mk_word(CMD_OUTCOME, 1'b1, 1'b0, 1'b0, '0, '0), 1'b1,
			done_word(RC_OK)});
		directed.push_back('{mk_word(CMD_START, 1'b1, 1'b1, 1'b1, '1, '1), 1'b1,
			cmd_word(SD_GO_IDLE, '0, RESP_NONE, 1'b0, 1'b0, DIR_NONE, 1'b0)});
		directed.push_back('{mk_word(CMD_OUTCOME, 1'b0, 1'b1, 1'b1, '1, '0), 1'b1,
			cmd_word(SD_SEND_IF_COND, 32'h1aa, RESP_48, 1'b1, 1'b1, DIR_NONE, 1'b0)});
		directed.push_back('{mk_word(CMD_OUTCOME, 1'b0, 1'b1, 1'b0, '0, '0), 1'b0, '0});
		directed.push_back('{mk_word(CMD_OUTCOME, 1'b1, 1'b0, 1'b0, 32'h1aa, '0), 1'b0, '0});
		directed.push_back('{mk_word(CMD_OUTCOME, 1'b1, 1'b0, 1'b0, '0, '0), 1'b0, '0});
		directed.push_back('{mk_word(CMD_OUTCOME, 1'b1, 1'b0, 1'b0, '0, '0), 1'b0, '0});
		directed.push_back('{mk_word(CMD_OUTCOME, 1'b1, 1'b0, 1'b0, '0, '0), 1'b0, '0});
		directed.push_back('{mk_word(CMD_OUTCOME, 1'b1, 1'b0, 1'b0, '1, '0), 1'b0, '0});
		directed.push_back('{mk_word(CMD_OUTCOME, 1'b1, 1'b0, 1'b0, '0, '0), 1'b0, '0});
		directed.push_back('{mk_word(CMD_OUTCOME, 1'b1, 1'b0, 1'b0, 32'habcd1234, '0), 1'b0, '0});
		directed.push_back('{mk_word(CMD_OUTCOME, 1'b1, 1'b0, 1'b0, '0, '0), 1'b0, '0});
		directed.push_back('{mk_word(CMD_OUTCOME, 1'b1, 1'b0, 1'b0, '0, '0), 1'b0, '0});
		directed.push_back('{mk_word(CMD_OUTCOME, 1'b1, 1'b0, 1'b0, '0, '0), 1'b0, '0});
		directed.push_back('{mk_word(CMD_OUTCOME, 1'b1, 1'b0, 1'b0, '0, '0), 1'b0, '0});
		directed.push_back('{mk_word(CMD_OUTCOME, 1'b1, 1'b0, 1'b1, '0, '0), 1'b0, '0});
		directed.push_back('{mk_word(CMD_READ, 1'b0, 1'b0, 1'b0, '0, '1), 1'b0, '0});
		directed.push_back('{mk_word(CMD_START, 1'b0, 1'b0, 1'b0, '0, '0), 1'b0, '0});
		directed.push_back('{mk_word(CMD_OUTCOME, 1'b1, 1'b0, 1'b0, '0, '0), 1'b0, '0});
		directed.push_back('{mk_word(CMD_OUTCOME, 1'b1, 1'b0, 1'b0, 32'h1ab, '0), 1'b0, '0});
		foreach (directed[i])
			offer(directed[i].w, directed[i].typed, directed[i].want, hit);

		// Random traffic under a series of register settings, extremes first
		for (int setting = 1; setting <= 7; setting++) begin
			settle();
			case (setting)
				1: program_regs(8'd255, 10'd1023, 12'd4095, 12'hfff, 24'hffffff);
				2: program_regs(8'd0, 10'd0, 12'd0, 12'h000, 24'h000000);
				3: program_regs(8'd1, 10'd1, 12'd1, 12'($urandom_range(0, 4095)),
					24'($urandom()));
				default: program_regs(8'($urandom_range(0, 3)), 10'($urandom_range(1, 6)),
					12'($urandom_range(1, 4095)), 12'($urandom_range(0, 4095)),
					24'($urandom()));
			endcase
			calm = (setting == 1);
			if (setting == 4)
				hold_req = 1'b1;
			made = 0;
			while (made < WORDS_PER_SETTING) begin
				w = pick_word();
				offer(w, 1'b0, '0, hit);
				made += int'(hit);
			end
		end
		calm = 1'b0;
		settle();

		if (planned_words.size() != 0) begin
			$error("%0d result words never arrived", planned_words.size());
			mismatches++;
		end
		$display("Sent %0d request words (%0d ignored) over %0d register settings; %0d checked.",
			words_sent, words_ignored, settings_used, words_checked);
		$display("Init sequences finished ok: %0d; block commands issued: %0d; mismatches: %0d.",
			inits_ok, block_cmds, mismatches);
		if (mismatches == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

endmodule
